// ===== hw/rtl/bqet_pkg.sv =====
// Shared constants, types and helper functions for the biquadratic escape-time unit.
// Used by every module of the block; depends on nothing else.
package bqet_pkg;

	// Number formats: Q4.28 at the ports, signed Q12.28 inside the block.
	localparam int IN_W      = 32;
	localparam int IN_FRAC   = 28;
	localparam int FRAC_BITS = 28;
	localparam int INT_BITS  = 12;
	localparam int IW        = FRAC_BITS + INT_BITS;
	localparam int EXT_W     = IW + 2;
	localparam int ITER_BITS = 16;
	localparam int MAX_W     = 16;

	// Port layout.
	localparam int S_TDATA_W  = 2 * IN_W;
	localparam int CODE_W     = 18;
	localparam int M_TDATA_W  = ((CODE_W + 7) / 8) * 8;
	localparam int CFG_IDX_W  = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_C_REAL   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_C_IMAG   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd2;

	// Register reset values.
	localparam logic [IN_W-1:0]  C_REAL_RST   = 32'd67108864;
	localparam logic [IN_W-1:0]  C_IMAG_RST   = 32'd0;
	localparam logic [MAX_W-1:0] MAX_ITER_RST = 16'd100;

	typedef logic signed [IW-1:0]    fix_t;
	typedef logic signed [EXT_W-1:0] ext_t;
	typedef logic [ITER_BITS-1:0]    iter_t;
	typedef logic [CODE_W-1:0]       code_t;

	// Largest interior magnitude; any result beyond it saturates.
	localparam fix_t MAG_MAX = {1'b0, {(IW-1){1'b1}}};
	// Escape radius squared (10.0) in interior format, one bit wider than a square.
	localparam logic [IW:0] ESC_LIMIT = (IW+1)'(10) << FRAC_BITS;

	// A value together with the flag that says it was clipped.
	typedef struct packed {
		fix_t val;
		logic sat;
	} sat_fix_t;

	// Per-point orbit constants a and b.
	typedef struct packed {
		fix_t are;
		fix_t aim;
		fix_t bre;
		fix_t bim;
	} orbit_cfg_t;

	// Clip a widened sum to the symmetric interior range.
	function automatic sat_fix_t sat_fix(input ext_t v);
		sat_fix_t r;
		if (v > ext_t'(MAG_MAX)) begin
			r.val = MAG_MAX;
			r.sat = 1'b1;
		end else if (v < -ext_t'(MAG_MAX)) begin
			r.val = -MAG_MAX;
			r.sat = 1'b1;
		end else begin
			r.val = v[IW-1:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

	// Convert a Q4.28 port value to the interior format; fewer fraction bits round down.
	function automatic fix_t to_fix(input logic signed [IN_W-1:0] v);
		if (FRAC_BITS >= IN_FRAC) begin
			return fix_t'(v) <<< ((FRAC_BITS >= IN_FRAC) ? FRAC_BITS - IN_FRAC : 0);
		end
		return fix_t'(v >>> ((FRAC_BITS < IN_FRAC) ? IN_FRAC - FRAC_BITS : 0));
	endfunction

endpackage

// ===== hw/rtl/bqet_mul.sv =====
// Shared sign-magnitude fixed-point multiplier built from four half-width partial products.
// Depends on bqet_pkg for the interior format and saturation limit.
module bqet_mul (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  bqet_pkg::fix_t op_a,
	input  bqet_pkg::fix_t op_b,
	output logic          done,
	output bqet_pkg::fix_t product,
	output logic          sat
);
	import bqet_pkg::*;

	localparam int PART_W = (IW + 1) / 2;
	localparam int ACC_W  = 2 * IW;

	typedef enum logic [1:0] {M_IDLE, M_ACC, M_FIN} mul_state_t;

	mul_state_t              state_q;
	logic [1:0]              step_q;
	logic [2*PART_W-1:0]     a_mag_q;
	logic [2*PART_W-1:0]     b_mag_q;
	logic                    neg_q;
	logic [ACC_W-1:0]        acc_q;
	logic                    done_q;
	fix_t                    product_q;
	logic                    sat_q;

	logic [IW-1:0]           a_abs;
	logic [IW-1:0]           b_abs;
	logic [PART_W-1:0]       part_a;
	logic [PART_W-1:0]       part_b;
	logic [2*PART_W-1:0]     part_prod;
	logic [ACC_W-1:0]        part_shifted;
	logic [ACC_W-1:0]        acc_scaled;
	logic                    fin_sat;
	fix_t                    fin_mag;

	// Operand magnitudes; operands never exceed the symmetric range.
	assign a_abs = op_a[IW-1] ? IW'(-op_a) : IW'(op_a);
	assign b_abs = op_b[IW-1] ? IW'(-op_b) : IW'(op_b);

	// One partial product per cycle, placed by the weight of its halves.
	assign part_a    = step_q[1] ? a_mag_q[2*PART_W-1:PART_W] : a_mag_q[PART_W-1:0];
	assign part_b    = step_q[0] ? b_mag_q[2*PART_W-1:PART_W] : b_mag_q[PART_W-1:0];
	assign part_prod = part_a * part_b;

	always_comb begin
		case (step_q)
			2'd0:    part_shifted = ACC_W'(part_prod);
			2'd3:    part_shifted = ACC_W'(part_prod) << (2 * PART_W);
			default: part_shifted = ACC_W'(part_prod) << PART_W;
		endcase
	end

	// Drop the fraction bits of the exact product and clip the magnitude.
	assign acc_scaled = acc_q >> FRAC_BITS;
	assign fin_sat    = acc_scaled > ACC_W'(MAG_MAX);
	assign fin_mag    = fin_sat ? MAG_MAX : fix_t'(acc_scaled[IW-1:0]);

	// Sequencer and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			step_q  <= 2'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == M_FIN);
			unique case (state_q)
				M_IDLE: begin
					if (start) begin
						a_mag_q <= (2*PART_W)'(a_abs);
						b_mag_q <= (2*PART_W)'(b_abs);
						neg_q   <= op_a[IW-1] ^ op_b[IW-1];
						acc_q   <= '0;
						step_q  <= 2'd0;
						state_q <= M_ACC;
					end
				end
				M_ACC: begin
					acc_q  <= acc_q + part_shifted;
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= M_FIN;
					end
				end
				M_FIN: begin
					product_q <= neg_q ? -fin_mag : fin_mag;
					sat_q     <= fin_sat;
					state_q   <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign done    = done_q;
	assign product = product_q;
	assign sat     = sat_q;

endmodule

// ===== hw/rtl/bqet_orbit.sv =====
// Orbit engine: runs one escape-time orbit of w -> (w^2+a)^2+b on the shared multiplier.
// Depends on bqet_pkg and instantiates bqet_mul.
module bqet_orbit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  bqet_pkg::fix_t     init_re,
	input  bqet_pkg::fix_t     init_im,
	input  bqet_pkg::orbit_cfg_t cfg,
	input  bqet_pkg::iter_t    lim,
	output logic               done,
	output bqet_pkg::iter_t    count
);
	import bqet_pkg::*;

	typedef enum logic [2:0] {
		O_IDLE, O_SQ_RE, O_SQ_IM, O_CHECK, O_MUL_T, O_UPD
	} orbit_state_t;

	// Where the orbit stands: initial squares, first half-step, second half-step.
	typedef enum logic [1:0] {PH_INIT, PH_A, PH_B} phase_t;

	orbit_state_t state_q;
	phase_t       phase_q;
	fix_t         re_q;
	fix_t         im_q;
	fix_t         re2_q;
	fix_t         im2_q;
	fix_t         t_q;
	logic         sat_q;
	iter_t        n_q;
	logic         issued_q;
	logic         done_q;

	logic         mul_start;
	fix_t         mul_a;
	fix_t         mul_b;
	logic         mul_done;
	fix_t         mul_p;
	logic         mul_sat;

	logic [IW:0]  esc_sum;
	logic         keep_going;
	fix_t         add_re;
	fix_t         add_im;
	sat_fix_t     t_dbl;
	sat_fix_t     im_new;
	sat_fix_t     re_new;

	// Multiplier operands follow the state: re*re, im*im or re*im.
	assign mul_a     = (state_q == O_SQ_IM) ? im_q : re_q;
	assign mul_b     = (state_q == O_SQ_RE) ? re_q : im_q;
	assign mul_start = ((state_q == O_SQ_RE) || (state_q == O_SQ_IM) ||
			(state_q == O_MUL_T)) && !issued_q;

	bqet_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.done    (mul_done),
		.product (mul_p),
		.sat     (mul_sat)
	);

	// Loop test before each step: limit, saturation and escape radius.
	assign esc_sum    = {1'b0, re2_q} + {1'b0, im2_q};
	assign keep_going = (n_q < lim) && !sat_q && (esc_sum < ESC_LIMIT);

	// Half-step update, a then b: im = 2*re*im + add_im, re = re^2 - im^2 + add_re.
	assign add_re = (phase_q == PH_B) ? cfg.bre : cfg.are;
	assign add_im = (phase_q == PH_B) ? cfg.bim : cfg.aim;
	assign t_dbl  = sat_fix(ext_t'(t_q) <<< 1);
	assign im_new = sat_fix(ext_t'(t_dbl.val) + ext_t'(add_im));
	assign re_new = sat_fix(ext_t'(re2_q) - ext_t'(im2_q) + ext_t'(add_re));

	// Orbit sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= O_IDLE;
			phase_q  <= PH_INIT;
			sat_q    <= 1'b0;
			n_q      <= '0;
			issued_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q   <= (state_q == O_CHECK) && !keep_going;
			issued_q <= mul_start || (issued_q && !mul_done);
			unique case (state_q)
				O_IDLE: begin
					if (start) begin
						re_q    <= init_re;
						im_q    <= init_im;
						sat_q   <= 1'b0;
						n_q     <= '0;
						phase_q <= PH_INIT;
						state_q <= O_SQ_RE;
					end
				end
				O_SQ_RE: begin
					if (mul_done) begin
						re2_q    <= mul_p;
						sat_q    <= sat_q | mul_sat;
						state_q  <= O_SQ_IM;
					end
				end
				O_SQ_IM: begin
					if (mul_done) begin
						im2_q    <= mul_p;
						sat_q    <= sat_q | mul_sat;
						unique case (phase_q)
							PH_A: begin
								phase_q <= PH_B;
								state_q <= O_MUL_T;
							end
							PH_B: begin
								n_q     <= n_q + 1'b1;
								state_q <= O_CHECK;
							end
							default: state_q <= O_CHECK;
						endcase
					end
				end
				O_CHECK: begin
					if (keep_going) begin
						phase_q <= PH_A;
						state_q <= O_MUL_T;
					end else begin
						state_q <= O_IDLE;
					end
				end
				O_MUL_T: begin
					if (mul_done) begin
						t_q      <= mul_p;
						sat_q    <= sat_q | mul_sat;
						state_q  <= O_UPD;
					end
				end
				O_UPD: begin
					re_q    <= re_new.val;
					im_q    <= im_new.val;
					sat_q   <= sat_q | t_dbl.sat | im_new.sat | re_new.sat;
					state_q <= O_SQ_RE;
				end
				default: state_q <= O_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign count = n_q;

endmodule

// ===== hw/rtl/biquadratic_escape_time_unit.sv =====
// Top level of the biquadratic escape-time unit: ports, configuration registers, control.
// Depends on bqet_pkg and instantiates bqet_orbit (which holds the shared multiplier).
//
//   Channel  Dir  Signals                            Transfer
//   s_*      in   s_tvalid s_tready s_tdata[63:0]    one plane point
//   m_*      out  m_tvalid m_tready m_tdata m_tuser  one color code per point
//   cfg_*    in   cfg_valid cfg_ready cfg_index      one register write
//                 cfg_data[31:0]
//
// One point at a time. Each multiply runs on the single shared multiplier, and each
// map step takes 6 multiplies, three for each of its two half-steps.
// s_tready is high only while no point is in work; cfg_ready is always high.
// A result waits in the output register, and the next point may be taken meanwhile.
// Reset clears control state and loads the register reset values.
module biquadratic_escape_time_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [bqet_pkg::S_TDATA_W-1:0]     s_tdata,   // point_re[31:0], point_im[63:32]
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [bqet_pkg::M_TDATA_W-1:0]     m_tdata,   // color_code[17:0], zero pad
	output logic                               m_tuser,   // both_bounded[0]
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bqet_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bqet_pkg::IN_W-1:0]          cfg_data
);
	import bqet_pkg::*;

	typedef enum logic [2:0] {T_IDLE, T_SETUP, T_ORB0, T_ORB1, T_OUT} top_state_t;

	top_state_t              state_q;
	logic signed [IN_W-1:0]  c_re_q;
	logic signed [IN_W-1:0]  c_im_q;
	logic [MAX_W-1:0]        max_iter_q;
	logic signed [IN_W-1:0]  point_re_q;
	logic signed [IN_W-1:0]  point_im_q;
	orbit_cfg_t              orb_cfg_q;
	iter_t                   lim_q;
	iter_t                   j_q;
	logic                    orb_start_q;
	logic                    m_tvalid_q;
	code_t                   code_q;
	logic                    both_q;

	fix_t                    zr;
	fix_t                    zi;
	fix_t                    cr;
	fix_t                    ci;
	sat_fix_t                a_re;
	sat_fix_t                a_im;
	sat_fix_t                z2_re;
	sat_fix_t                z2_im;
	sat_fix_t                b_re;
	sat_fix_t                b_im;
	fix_t                    init_re;
	fix_t                    init_im;
	logic                    orb_done;
	iter_t                   orb_count;
	logic                    both_hit;
	code_t                   code_next;
	logic                    out_free;
	logic                    s_xfer;

	assign s_tready  = (state_q == T_IDLE);
	assign s_xfer    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Configuration registers; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_re_q     <= C_REAL_RST;
			c_im_q     <= C_IMAG_RST;
			max_iter_q <= MAX_ITER_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_C_REAL:   c_re_q     <= cfg_data;
				REG_C_IMAG:   c_im_q     <= cfg_data;
				REG_MAX_ITER: max_iter_q <= cfg_data[MAX_W-1:0];
				default: ;
			endcase
		end
	end

	// Per-point constants: a = c + z, b = conj(c) + 2z.
	assign zr    = to_fix(point_re_q);
	assign zi    = to_fix(point_im_q);
	assign cr    = to_fix(c_re_q);
	assign ci    = to_fix(c_im_q);
	assign a_re  = sat_fix(ext_t'(cr) + ext_t'(zr));
	assign a_im  = sat_fix(ext_t'(ci) + ext_t'(zi));
	assign z2_re = sat_fix(ext_t'(zr) <<< 1);
	assign z2_im = sat_fix(ext_t'(zi) <<< 1);
	assign b_re  = sat_fix(ext_t'(cr) + ext_t'(z2_re.val));
	assign b_im  = sat_fix(ext_t'(z2_im.val) - ext_t'(ci));

	// The first orbit starts at zero, the second at b.
	assign init_re = (state_q == T_ORB1) ? orb_cfg_q.bre : '0;
	assign init_im = (state_q == T_ORB1) ? orb_cfg_q.bim : '0;

	bqet_orbit u_orbit (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (orb_start_q),
		.init_re (init_re),
		.init_im (init_im),
		.cfg     (orb_cfg_q),
		.lim     (lim_q),
		.done    (orb_done),
		.count   (orb_count)
	);

	// Color code from the two counts: j from the first orbit, i from the second.
	assign both_hit = (orb_count >= lim_q) && (j_q >= lim_q);
	always_comb begin
		if (both_hit) begin
			code_next = '1;
		end else if (orb_count < j_q) begin
			code_next = CODE_W'({j_q, 1'b0});
		end else begin
			code_next = CODE_W'({orb_count, 1'b1});
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	// Control sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			orb_start_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			orb_start_q <= (state_q == T_SETUP) || ((state_q == T_ORB0) && orb_done);
			m_tvalid_q  <= ((state_q == T_OUT) && out_free) || (m_tvalid_q && !m_tready);
			unique case (state_q)
				T_IDLE: begin
					if (s_xfer) begin
						point_re_q <= s_tdata[IN_W-1:0];
						point_im_q <= s_tdata[2*IN_W-1:IN_W];
						state_q    <= T_SETUP;
					end
				end
				T_SETUP: begin
					orb_cfg_q.are <= a_re.val;
					orb_cfg_q.aim <= a_im.val;
					orb_cfg_q.bre <= b_re.val;
					orb_cfg_q.bim <= b_im.val;
					// A limit wider than the count saturates to the largest count.
					lim_q         <= ((max_iter_q >> ITER_BITS) != '0) ? '1 :
							ITER_BITS'(max_iter_q);
					state_q       <= T_ORB0;
				end
				T_ORB0: begin
					if (orb_done) begin
						j_q         <= orb_count;
						state_q     <= T_ORB1;
					end
				end
				T_ORB1: begin
					if (orb_done) begin
						state_q <= T_OUT;
					end
				end
				T_OUT: begin
					if (out_free) begin
						code_q     <= code_next;
						both_q     <= both_hit;
						state_q    <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(code_q);
	assign m_tuser  = both_q;

endmodule

// ===== hw/rtl/bqet_checker.sv =====
// Port-level checks for the biquadratic escape-time unit, bound to the top level.
// Depends on bqet_pkg for port widths.
module bqet_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [bqet_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                           m_tuser
);
	import bqet_pkg::*;

	// A point in work blocks the next input transfer.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after an input transfer");

	// Both orbits bounded always reads as the all-ones code.
	a_bounded_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[CODE_W-1:0] == {CODE_W{1'b1}})
		else $error("both_bounded set without the all-ones code");

	// Pad bits above the code stay zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_TDATA_W-1:CODE_W] == '0)
		else $error("nonzero pad bits in result");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind biquadratic_escape_time_unit bqet_checker u_bqet_checker (.*);
